// File: rtl/core/rle_pkg.sv
// rle_pkg: shared types and constants for the ring leader election node.
// Depends on nothing; imported by every module of the block.
package rle_pkg;

  // Highest round whose budget is sent; the round counter stops one past it
  localparam int unsigned MaxRound = 15;
  localparam int RankW   = 7;
  localparam int BudgetW = 16;
  localparam int RoundW  = 5;
  localparam int ShiftW  = 4;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_PROBE = 2'd1,
    CMD_REPLY = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    MSG_PROBE   = 2'd0,
    MSG_REPLY   = 2'd1,
    MSG_COLLECT = 2'd2
  } msg_kind_t;

  typedef enum logic [1:0] {
    ST_LOSER   = 2'd0,
    ST_LEADER  = 2'd1,
    ST_UNKNOWN = 2'd2
  } status_t;

  // Configuration register indexes
  typedef enum logic {
    REG_OWN_RANK        = 1'b0,
    REG_START_INITIATOR = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [RankW-1:0] own_rank;
    logic             start_initiator;
  } cfg_t;

  // One queued action: a single message, or a round start (two probes)
  typedef struct packed {
    logic               is_round;
    logic               to_succ;
    msg_kind_t          kind;
    logic [RankW-1:0]   init;
    logic [BudgetW-1:0] budget;
    status_t            status;
  } action_t;

endpackage

// File: rtl/core/ring_leader_election_node.sv
// ring_leader_election_node: top level, configuration registers and the
// front / queue / back chain. Depends on rle_pkg, rle_front, rle_queue, rle_back.
//
//  channel   handshake           payload
//  input     push / full         command, arrived_from_pred, initiator_rank, hop_budget
//  result    pop / empty         to_successor, message_kind, msg_initiator,
//                                msg_budget, node_status, last
//  config    APB psel/penable    paddr, pwdata, prdata (pready tied high)
//
// One item is accepted per cycle while the two-entry queue has room.
// Results leave at one per cycle while pop is asserted: a round start gives two
// results and other items one or none, so the back end sets the item rate.
// Synchronous active-high reset empties the queue and output and clears election state.
// A stalled result side fills the queue, then raises full.
module ring_leader_election_node
  import rle_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         command,
  input  logic               arrived_from_pred,
  input  logic [RankW-1:0]   initiator_rank,
  input  logic [BudgetW-1:0] hop_budget,
  output logic               empty,
  input  logic               pop,
  output logic               to_successor,
  output logic [1:0]         message_kind,
  output logic [RankW-1:0]   msg_initiator,
  output logic [BudgetW-1:0] msg_budget,
  output logic [1:0]         node_status,
  output logic               last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t     cfg;
  reg_idx_t reg_sel;
  logic     cfg_wr;
  logic     q_full, q_push, q_valid, q_rd;
  action_t  q_in, q_out;

  // Configuration port
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_rank        <= RankW'(1);
      cfg.start_initiator <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_OWN_RANK:        cfg.own_rank        <= pwdata[RankW-1:0];
        REG_START_INITIATOR: cfg.start_initiator <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_OWN_RANK:        prdata = {{(32-RankW){1'b0}}, cfg.own_rank};
      REG_START_INITIATOR: prdata = {31'b0, cfg.start_initiator};
      default:             prdata = '0;
    endcase
  end

  rle_front u_front (
    .clk               (clk),
    .rst               (rst),
    .push              (push),
    .full              (full),
    .command           (command),
    .arrived_from_pred (arrived_from_pred),
    .initiator_rank    (initiator_rank),
    .hop_budget        (hop_budget),
    .cfg               (cfg),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_data            (q_in)
  );

  rle_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_in),
    .q_full  (q_full),
    .rd_en   (q_rd),
    .q_valid (q_valid),
    .rd_data (q_out)
  );

  rle_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_data        (q_out),
    .rd_en         (q_rd),
    .empty         (empty),
    .pop           (pop),
    .to_successor  (to_successor),
    .message_kind  (message_kind),
    .msg_initiator (msg_initiator),
    .msg_budget    (msg_budget),
    .node_status   (node_status),
    .last          (last)
  );

endmodule

// File: rtl/core/rle_front.sv
// rle_front: accepts items, updates the election state, classifies the item
// into a queued action. Depends on rle_pkg.
module rle_front
  import rle_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         command,
  input  logic               arrived_from_pred,
  input  logic [RankW-1:0]   initiator_rank,
  input  logic [BudgetW-1:0] hop_budget,
  input  cfg_t               cfg,
  input  logic               q_full,
  output logic               q_push,
  output action_t            q_data
);

  logic              initiator_flag, initiator_flag_next;
  logic [RoundW-1:0] round_count, round_count_next;
  logic [1:0]        replies_seen, replies_seen_next;
  status_t           election_status, election_status_next;

  logic              accept;
  logic              act_valid;
  logic              do_round;
  logic [ShiftW-1:0] shift;
  logic [1:0]        replies_inc;

  assign full   = q_full;
  assign accept = push && !q_full;

  // Round budget: 1 << min(round, MaxRound)
  assign shift = (round_count > RoundW'(MaxRound)) ? ShiftW'(MaxRound)
                                                   : round_count[ShiftW-1:0];
  assign replies_inc = (replies_seen == 2'd3) ? 2'd3 : replies_seen + 2'd1;

  // Classification and next state
  always_comb begin
    initiator_flag_next  = initiator_flag;
    round_count_next     = round_count;
    replies_seen_next    = replies_seen;
    election_status_next = election_status;
    act_valid            = 1'b0;
    do_round             = 1'b0;
    q_data               = '0;
    q_data.kind          = MSG_PROBE;
    case (cmd_t'(command))
      CMD_START: begin
        initiator_flag_next = cfg.start_initiator;
        if (cfg.start_initiator && round_count == '0) do_round = 1'b1;
      end
      CMD_PROBE: begin
        if (initiator_rank > cfg.own_rank) begin
          election_status_next = ST_LOSER;
          act_valid            = 1'b1;
          if (hop_budget > BudgetW'(1)) begin
            q_data.to_succ = arrived_from_pred;
            q_data.kind    = MSG_PROBE;
            q_data.budget  = hop_budget - BudgetW'(1);
          end else begin
            q_data.to_succ = !arrived_from_pred;
            q_data.kind    = MSG_REPLY;
            q_data.budget  = '0;
          end
          q_data.init = initiator_rank;
        end else if (initiator_rank == cfg.own_rank && election_status != ST_LEADER) begin
          election_status_next = ST_LEADER;
          act_valid            = 1'b1;
          q_data.to_succ       = 1'b1;
          q_data.kind          = MSG_COLLECT;
          q_data.init          = cfg.own_rank;
          q_data.budget        = '0;
        end else if (!initiator_flag) begin
          initiator_flag_next = 1'b1;
          if (round_count == '0) do_round = 1'b1;
        end
      end
      CMD_REPLY: begin
        if (initiator_rank != cfg.own_rank) begin
          act_valid      = 1'b1;
          q_data.to_succ = arrived_from_pred;
          q_data.kind    = MSG_REPLY;
          q_data.init    = initiator_rank;
          q_data.budget  = hop_budget;
        end else begin
          replies_seen_next = replies_inc;
          if (replies_inc == 2'd2) do_round = 1'b1;
        end
      end
      default: ;
    endcase
    // Round start: two probes, clear replies, mark initiator, advance round up to MaxRound + 1
    if (do_round) begin
      act_valid         = 1'b1;
      q_data.is_round   = 1'b1;
      q_data.kind       = MSG_PROBE;
      q_data.init       = cfg.own_rank;
      q_data.budget     = BudgetW'(1) << shift;
      replies_seen_next = '0;
      if (round_count == '0) initiator_flag_next = 1'b1;
      if (round_count <= RoundW'(MaxRound)) round_count_next = round_count + RoundW'(1);
    end
    q_data.status = election_status_next;
  end

  assign q_push = accept && act_valid;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      initiator_flag  <= 1'b0;
      round_count     <= '0;
      replies_seen    <= '0;
      election_status <= ST_UNKNOWN;
    end else if (accept) begin
      initiator_flag  <= initiator_flag_next;
      round_count     <= round_count_next;
      replies_seen    <= replies_seen_next;
      election_status <= election_status_next;
    end
  end

endmodule

// File: rtl/core/rle_queue.sv
// rle_queue: two-entry action queue between front and back.
// Depends on rle_pkg.
module rle_queue
  import rle_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    wr_en,
  input  action_t wr_data,
  output logic    q_full,
  input  logic    rd_en,
  output logic    q_valid,
  output action_t rd_data
);

  action_t    mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign q_full  = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign rd_data = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wr_data;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= !wr_ptr;
      if (rd_en) rd_ptr <= !rd_ptr;
      case ({wr_en, rd_en})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/core/rle_back.sv
// rle_back: output register; expands each action into one or two result
// items. Depends on rle_pkg.
module rle_back
  import rle_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  action_t            q_data,
  output logic               rd_en,
  output logic               empty,
  input  logic               pop,
  output logic               to_successor,
  output logic [1:0]         message_kind,
  output logic [RankW-1:0]   msg_initiator,
  output logic [BudgetW-1:0] msg_budget,
  output logic [1:0]         node_status,
  output logic               last
);

  logic    valid;
  logic    second;
  action_t act;
  logic    done;

  // Final item of the held action is being taken (or nothing held)
  assign done  = !valid || (pop && (!act.is_round || second));
  assign rd_en = q_valid && done;
  assign empty = !valid;

  assign to_successor  = act.is_round ? second : act.to_succ;
  assign message_kind  = act.kind;
  assign msg_initiator = act.init;
  assign msg_budget    = act.budget;
  assign node_status   = act.status;
  assign last          = !act.is_round || second;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= 1'b0;
      second <= 1'b0;
    end else if (done) begin
      valid  <= q_valid;
      second <= 1'b0;
    end else if (pop) begin
      second <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (rd_en) act <= q_data;
  end

endmodule
